// ----- rtl/cimfd_pkg.sv -----
// Package with request codes, status codes and the queued command type of the CAN filter table.
`timescale 1ns / 1ps
package cimfd_pkg;

  localparam int RESULT_CAP = 16;
  localparam int QDEPTH     = 2;

  typedef enum logic [1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_UNREGISTER = 2'd1,
    REQ_DISPATCH   = 2'd2,
    REQ_UNKNOWN    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STAT_DONE    = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_BADSLOT = 3'd2,
    STAT_NOMATCH = 3'd3,
    STAT_MATCH   = 3'd4
  } status_t;

  typedef struct packed {
    req_t        op;
    logic        in_range;
    logic [31:0] mask;
    logic [31:0] filter;
    logic [7:0]  tag;
    logic [5:0]  idx;
    logic [31:0] fid;
  } cmd_t;

endpackage

// ----- rtl/cimfd_front.sv -----
// Request intake: classifies requests, drops unknown types and queues commands for the table.
`timescale 1ns / 1ps
module cimfd_front
  import cimfd_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_mask_value,
  input  logic [31:0] in_filter_value,
  input  logic [7:0]  in_dest_tag,
  input  logic [5:0]  in_slot_index,
  input  logic [31:0] in_frame_id,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  cmd_t       q_mem_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.op       = req_t'(in_req_type);
    cmd_in.in_range = ({1'b0, in_slot_index} < 7'(SLOTS));
    cmd_in.mask     = in_mask_value;
    cmd_in.filter   = in_filter_value;
    cmd_in.tag      = in_dest_tag;
    cmd_in.idx      = in_slot_index;
    cmd_in.fid      = in_frame_id;
  end

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];
  // unknown request types are taken and dropped
  assign push     = in_valid && in_ready && (cmd_in.op != REQ_UNKNOWN);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/cimfd_back.sv -----
// Slot table: register, unregister, one-slot-per-cycle dispatch scan unless stalled, output register.
`timescale 1ns / 1ps
module cimfd_back
  import cimfd_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot_out,
  output logic [7:0]  out_tag_out,
  output logic        out_last
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW = $clog2(SLOTS + 1);
  localparam int HW = $clog2(RESULT_CAP + 1);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SCAN  = 3'b010,
    B_FLUSH = 3'b100
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [31:0] mask_mem   [SLOTS];
  logic [31:0] filter_mem [SLOTS];
  logic [7:0]  tag_mem    [SLOTS];

  logic [SLOTS-1:0] used_r, used_nxt;
  logic [31:0]      rd_mask_r, rd_filter_r;
  logic [7:0]       rd_tag_r;
  logic             rd_en;
  logic             wr_en;

  logic [31:0]   fid_r, fid_nxt;
  logic [IW-1:0] iss_r, iss_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [SW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [SW-1:0] pend_idx_r, pend_idx_nxt;
  logic [7:0]    pend_tag_r, pend_tag_nxt;
  logic [HW-1:0] hits_r, hits_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r;
  logic [5:0]    out_slot_r;
  logic [7:0]    out_tag_r;
  logic          out_last_r;

  logic          emit;
  status_t       em_status;
  logic [5:0]    em_slot;
  logic [7:0]    em_tag;
  logic          em_last;

  logic          out_free;
  logic          any_free;
  logic [SW-1:0] free_idx;
  logic [SW-1:0] uidx;
  logic          hit;
  logic          stall;
  logic          done;

  assign out_free = !out_valid_r || out_ready;
  assign uidx     = q_cmd.idx[SW-1:0];
  assign hit      = cmp_v_r && used_r[cmp_idx_r] &&
                    (((fid_r ^ rd_filter_r) & rd_mask_r) == 32'd0);

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        any_free = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    fid_nxt      = fid_r;
    iss_nxt      = iss_r;
    cmp_v_nxt    = cmp_v_r;
    cmp_idx_nxt  = cmp_idx_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    pend_tag_nxt = pend_tag_r;
    hits_nxt     = hits_r;
    q_pop        = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    emit         = 1'b0;
    em_status    = STAT_DONE;
    em_slot      = 6'd0;
    em_tag       = 8'd0;
    em_last      = 1'b1;
    stall        = 1'b0;
    done         = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            REQ_REGISTER: begin
              emit = 1'b1;
              if (any_free) begin
                wr_en              = 1'b1;
                used_nxt[free_idx] = 1'b1;
                em_status          = STAT_DONE;
                em_slot            = 6'(free_idx);
              end else begin
                em_status = STAT_FULL;
              end
            end
            REQ_UNREGISTER: begin
              emit = 1'b1;
              if (q_cmd.in_range && used_r[uidx]) begin
                used_nxt[uidx] = 1'b0;
                em_status      = STAT_DONE;
              end else begin
                em_status = STAT_BADSLOT;
              end
            end
            REQ_DISPATCH: begin
              fid_nxt    = q_cmd.fid;
              iss_nxt    = '0;
              cmp_v_nxt  = 1'b0;
              pend_v_nxt = 1'b0;
              hits_nxt   = '0;
              state_nxt  = B_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      B_SCAN: begin
        stall = hit && pend_v_r && !out_free;
        if (!stall) begin
          if (hit && pend_v_r) begin
            emit      = 1'b1;
            em_status = STAT_MATCH;
            em_slot   = 6'(pend_idx_r);
            em_tag    = pend_tag_r;
            em_last   = 1'b0;
          end
          if (hit) begin
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = cmp_idx_r;
            pend_tag_nxt = rd_tag_r;
            hits_nxt     = hits_r + HW'(1);
          end
          done = (cmp_v_r && (cmp_idx_r == SW'(SLOTS - 1))) ||
                 (hit && (hits_r == HW'(RESULT_CAP - 1)));
          if (done) begin
            cmp_v_nxt = 1'b0;
            state_nxt = B_FLUSH;
          end else if (iss_r != IW'(SLOTS)) begin
            rd_en       = 1'b1;
            cmp_v_nxt   = 1'b1;
            cmp_idx_nxt = iss_r[SW-1:0];
            iss_nxt     = iss_r + IW'(1);
          end else begin
            cmp_v_nxt = 1'b0;
          end
        end
      end
      B_FLUSH: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = B_IDLE;
          if (pend_v_r) begin
            em_status = STAT_MATCH;
            em_slot   = 6'(pend_idx_r);
            em_tag    = pend_tag_r;
          end else begin
            em_status = STAT_NOMATCH;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_mem[free_idx]   <= q_cmd.mask;
      filter_mem[free_idx] <= q_cmd.filter;
      tag_mem[free_idx]    <= q_cmd.tag;
    end
    if (rd_en) begin
      rd_mask_r   <= mask_mem[iss_r[SW-1:0]];
      rd_filter_r <= filter_mem[iss_r[SW-1:0]];
      rd_tag_r    <= tag_mem[iss_r[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    fid_r      <= fid_nxt;
    iss_r      <= iss_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_tag_r <= pend_tag_nxt;
    hits_r     <= hits_nxt;
    if (emit) begin
      out_status_r <= em_status;
      out_slot_r   <= em_slot;
      out_tag_r    <= em_tag;
      out_last_r   <= em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      used_r      <= '0;
      cmp_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cmp_v_r     <= cmp_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot_out = out_slot_r;
  assign out_tag_out  = out_tag_r;
  assign out_last     = out_last_r;

endmodule

// ----- rtl/can_id_mask_filter_dispatch_core.sv -----
// Top level of the CAN identifier mask/filter table with frame dispatch.
// A request is register (lowest free slot, returns its index or table full), unregister
// (frees a used slot, else bad slot) or dispatch (one match result per used slot whose
// masked filter equals the masked frame id, in slot order, last one marked; a single
// no-match result when none hits; at most 16 results). Type 3 is taken and dropped.
// Requests go through a two-entry queue to the table engine. Register and unregister
// are handled in the idle state when the output is free; dispatch scans one slot per
// cycle through the registered table read while the output is not stalled. The table is
// empty after reset, with no clearing pass.
`timescale 1ns / 1ps
module can_id_mask_filter_dispatch_core
  import cimfd_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_mask_value,
  input  logic [31:0] in_filter_value,
  input  logic [7:0]  in_dest_tag,
  input  logic [5:0]  in_slot_index,
  input  logic [31:0] in_frame_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot_out,
  output logic [7:0]  out_tag_out,
  output logic        out_last
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  cimfd_front #(.SLOTS(SLOTS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_mask_value   (in_mask_value),
    .in_filter_value (in_filter_value),
    .in_dest_tag     (in_dest_tag),
    .in_slot_index   (in_slot_index),
    .in_frame_id     (in_frame_id),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop)
  );

  cimfd_back #(.SLOTS(SLOTS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_slot_out (out_slot_out),
    .out_tag_out  (out_tag_out),
    .out_last     (out_last)
  );

endmodule

// ----- sim/can_filter_checker.sv -----
// Checker for the CAN filter table: tracks the slot table, predicts results and compares them.
`timescale 1ns / 1ps
module can_filter_checker
  import cimfd_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_mask_value,
  input  logic [31:0] in_filter_value,
  input  logic [7:0]  in_dest_tag,
  input  logic [5:0]  in_slot_index,
  input  logic [31:0] in_frame_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [5:0]  out_slot_out,
  input  logic [7:0]  out_tag_out,
  input  logic        out_last,
  output int          errors,
  output int          pending,
  output int          checked,
  output int          hit_count,
  output int          miss_count,
  output int          full_count,
  output int          bad_count
);

  typedef struct packed {
    status_t    status;
    logic [5:0] slot;
    logic [7:0] tag;
    logic       last;
  } route_t;

  route_t      route_q[$];
  logic        slot_used[SLOTS];
  logic [31:0] slot_mask[SLOTS];
  logic [31:0] slot_filter[SLOTS];
  logic [7:0]  slot_tag[SLOTS];

  initial begin
    errors     = 0;
    pending    = 0;
    checked    = 0;
    hit_count  = 0;
    miss_count = 0;
    full_count = 0;
    bad_count  = 0;
  end

  function automatic route_t make_route(status_t s, int slot, logic [7:0] tag, logic last);
    route_t r;
    r.status = s;
    r.slot   = 6'(slot);
    r.tag    = tag;
    r.last   = last;
    return r;
  endfunction

  task automatic route_request(input req_t op, input logic [31:0] mask,
                               input logic [31:0] filter, input logic [7:0] tag,
                               input logic [5:0] idx, input logic [31:0] fid);
    int i;
    int free_slot;
    int hits;
    case (op)
      REQ_REGISTER: begin
        free_slot = -1;
        for (i = 0; i < SLOTS; i++) begin
          if (!slot_used[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) begin
          route_q.push_back(make_route(STAT_FULL, 0, 8'd0, 1'b1));
        end else begin
          slot_used[free_slot]   = 1'b1;
          slot_mask[free_slot]   = mask;
          slot_filter[free_slot] = filter;
          slot_tag[free_slot]    = tag;
          route_q.push_back(make_route(STAT_DONE, free_slot, 8'd0, 1'b1));
        end
      end
      REQ_UNREGISTER: begin
        if (int'(idx) < SLOTS && slot_used[idx]) begin
          slot_used[idx]   = 1'b0;
          slot_mask[idx]   = '0;
          slot_filter[idx] = '0;
          slot_tag[idx]    = '0;
          route_q.push_back(make_route(STAT_DONE, 0, 8'd0, 1'b1));
        end else begin
          route_q.push_back(make_route(STAT_BADSLOT, 0, 8'd0, 1'b1));
        end
      end
      REQ_DISPATCH: begin
        hits = 0;
        for (i = 0; i < SLOTS; i++) begin
          if (hits < RESULT_CAP && slot_used[i] &&
              (fid & slot_mask[i]) == (slot_filter[i] & slot_mask[i])) begin
            route_q.push_back(make_route(STAT_MATCH, i, slot_tag[i], 1'b0));
            hits++;
          end
        end
        if (hits == 0) route_q.push_back(make_route(STAT_NOMATCH, 0, 8'd0, 1'b1));
        else route_q[route_q.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    route_t want;
    if (!rst_n) begin
      route_q.delete();
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i]   = 1'b0;
        slot_mask[i]   = '0;
        slot_filter[i] = '0;
        slot_tag[i]    = '0;
      end
    end else begin
      if (in_valid && in_ready) begin
        route_request(req_t'(in_req_type), in_mask_value, in_filter_value, in_dest_tag,
                      in_slot_index, in_frame_id);
      end
      if (out_valid && out_ready) begin
        if (route_q.size() == 0) begin
          $error("unexpected result: status %0d slot %0d tag %0d last %0d",
                 out_status, out_slot_out, out_tag_out, out_last);
          errors++;
        end else begin
          want = route_q.pop_front();
          checked++;
          case (want.status)
            STAT_MATCH:   hit_count++;
            STAT_NOMATCH: miss_count++;
            STAT_FULL:    full_count++;
            STAT_BADSLOT: bad_count++;
            default: ;
          endcase
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_slot_out !== want.slot) begin
            $error("slot_out: expected %0d, got %0d", want.slot, out_slot_out);
            errors++;
          end
          if (out_tag_out !== want.tag) begin
            $error("tag_out: expected 0x%0h, got 0x%0h", want.tag, out_tag_out);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            errors++;
          end
        end
      end
    end
    pending <= route_q.size();
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the CAN filter table: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module tb;
  import cimfd_pkg::*;

  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 122;
  localparam int HOLD_CYCLES  = 200;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type     = '0;
  logic [31:0] in_mask_value   = '0;
  logic [31:0] in_filter_value = '0;
  logic [7:0]  in_dest_tag     = '0;
  logic [5:0]  in_slot_index   = '0;
  logic [31:0] in_frame_id     = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [2:0]  out_status;
  logic [5:0]  out_slot_out;
  logic [7:0]  out_tag_out;
  logic        out_last;

  int errors, pending, checked, hit_count, miss_count, full_count, bad_count;
  int requests_sent = 0;
  bit held_off      = 1'b0;
  logic [31:0] id_pool[8];

  always #10 clk = ~clk;

  can_id_mask_filter_dispatch_core #(.SLOTS(SLOTS)) uut (.*);

  can_filter_checker #(.SLOTS(SLOTS)) chk (.*);

  function automatic bit steady_phase();
    return requests_sent >= 100 && requests_sent < 140;
  endfunction

  task automatic send(input req_t op, input logic [31:0] mask, input logic [31:0] filter,
                      input logic [7:0] tag, input logic [5:0] idx, input logic [31:0] fid);
    while (!steady_phase() && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= op;
    in_mask_value   <= mask;
    in_filter_value <= filter;
    in_dest_tag     <= tag;
    in_slot_index   <= idx;
    in_frame_id     <= fid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // receiver: random stalls, one long hold-off to back the block up, a stall-free stretch
  initial begin
    forever begin
      @(posedge clk);
      if (!held_off && requests_sent >= 70) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (steady_phase()) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    int n, sel;
    req_t op;
    logic [31:0] m, f, fid;
    logic [5:0] ix;

    for (n = 0; n < 8; n++) id_pool[n] = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send(REQ_DISPATCH, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send(REQ_UNREGISTER, '0, '0, '0, 6'd0, '0);
    send(REQ_UNREGISTER, '0, '0, '0, 6'd63, '0);
    send(REQ_UNKNOWN, '1, '1, '1, '1, '1);
    send(REQ_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, '0, '0);
    send(REQ_REGISTER, 32'hFFFF_FFFF, 32'h0000_0000, 8'hFF, '0, '0);
    send(REQ_DISPATCH, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send(REQ_DISPATCH, '0, '0, '0, '0, 32'h0000_0000);
    send(REQ_DISPATCH, '0, '0, '0, '0, 32'h0000_0001);
    send(REQ_UNREGISTER, '0, '0, '0, 6'd1, '0);
    for (n = 0; n < SLOTS - 1; n++) send(REQ_REGISTER, '0, $urandom, 8'($urandom), '0, '0);
    send(REQ_REGISTER, $urandom, $urandom, 8'($urandom), '0, '0);
    send(REQ_DISPATCH, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send(REQ_UNREGISTER, '0, '0, '0, 6'(SLOTS), '0);

    // random: pooled ids and coarse masks so dispatches hit often
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(99);
      if (sel < 30) op = REQ_REGISTER;
      else if (sel < 55) op = REQ_UNREGISTER;
      else if (sel < 95) op = REQ_DISPATCH;
      else op = REQ_UNKNOWN;
      case ($urandom_range(5))
        0: m = 32'h0000_07FF;
        1: m = 32'h1FFF_FFFF;
        2: m = 32'hFFFF_FFFF;
        3: m = 32'h0000_0000;
        4: m = $urandom;
        default: m = $urandom & $urandom;
      endcase
      f   = ($urandom_range(3) != 0) ? id_pool[$urandom_range(7)] : $urandom;
      fid = ($urandom_range(3) != 0) ?
            id_pool[$urandom_range(7)] ^ {3'($urandom_range(7)), 29'd0} : $urandom;
      ix  = ($urandom_range(4) != 0) ? 6'($urandom_range(SLOTS - 1)) :
            6'($urandom_range(63, SLOTS));
      send(op, m, f, 8'($urandom), ix, fid);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * SLOTS) @(posedge clk);

    if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("summary: %0d requests, %0d results checked", requests_sent, checked);
    $display("  %0d match, %0d no-match, %0d table full, %0d bad slot",
             hit_count, miss_count, full_count, bad_count);
    if (errors == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cimfd_pkg.sv
rtl/cimfd_front.sv
rtl/cimfd_back.sv
rtl/can_id_mask_filter_dispatch_core.sv
sim/can_filter_checker.sv
sim/tb.sv
